>>> rtl/brf_pkg.sv
// shared types and codes for the byte ring fifo with backspace
package brf_pkg;

  typedef enum logic [1:0] {
    ACT_PUT       = 2'd0,
    ACT_GET       = 2'd1,
    ACT_BACKSPACE = 2'd2,
    ACT_CLEAR     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RESP = 1'b1
  } state_t;

  localparam int DATA_W  = 8;
  localparam int FILL_W  = 8;
  localparam int CODE_W  = 2;

  typedef struct packed {
    logic exec;
  } cmd_t;

endpackage

>>> rtl/byte_ring_fifo_with_backspace.sv
// top level of the byte ring fifo with backspace
//
//  channel | ports            | tuser        | tdata
//  --------+------------------+--------------+------------------------------------
//  input   | in_tvalid/tready | [1:0] action | [7:0] data_in
//  output  | out_tvalid/tready| [1:0] status | [7:0] data_out, [15:8] fill_count
//
// one word at a time: a word is accepted and its result is offered from the next
// cycle; in_tready stays low while a result is offered, so no new word is
// accepted until the result is taken
// a stalled result holds in_tready low until out_tready takes it
// rst_n clears pointers and count; slot contents are not cleared
module byte_ring_fifo_with_backspace #(
  parameter int SLOT_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_in
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] data_out, [15:8] fill_count
  output logic [1:0]  out_tuser   // [1:0] status
);
  import brf_pkg::*;

  cmd_t              cmd;
  logic [DATA_W-1:0] data_out;
  logic [FILL_W-1:0] fill_count;

  brf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  brf_dpath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .action     (in_tuser),
    .data_in    (in_tdata),
    .status     (out_tuser),
    .data_out   (data_out),
    .fill_count (fill_count)
  );

  assign out_tdata = {fill_count, data_out};

endmodule

>>> rtl/brf_ctrl.sv
// handshake controller: takes one word, then holds its result until taken
module brf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output brf_pkg::cmd_t cmd
);
  import brf_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd.exec   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.exec  = in_tvalid;
      end
      S_RESP: begin
        out_tvalid = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/brf_dpath.sv
// datapath: slot memory, pointers, fill count and result registers
module brf_dpath #(
  parameter int SLOT_COUNT = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  brf_pkg::cmd_t                 cmd,
  input  logic [brf_pkg::CODE_W-1:0]    action,
  input  logic [brf_pkg::DATA_W-1:0]    data_in,
  output logic [brf_pkg::CODE_W-1:0]    status,
  output logic [brf_pkg::DATA_W-1:0]    data_out,
  output logic [brf_pkg::FILL_W-1:0]    fill_count
);
  import brf_pkg::*;

  localparam int PW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [PW-1:0] LAST_SLOT = PW'(SLOT_COUNT - 1);
  localparam logic [PW-1:0] SLOT_LOW  = PW'(SLOT_COUNT);

  logic [DATA_W-1:0] mem [SLOT_COUNT];

  logic [PW-1:0]     rp_r, rp_nxt;
  logic [PW-1:0]     wp_r, wp_nxt;
  logic [PW-1:0]     cnt_r, cnt_nxt;
  logic [CODE_W-1:0] status_r, status_nxt;
  logic              get_ok_r, get_ok_nxt;
  logic [DATA_W-1:0] rd_r;
  logic              we, re;
  logic              empty;
  logic [PW-1:0]     wp_inc, wp_dec, rp_inc;
  logic [PW:0]       diff;

  assign wp_inc = (wp_r == LAST_SLOT) ? '0 : wp_r + 1'b1;
  assign rp_inc = (rp_r == LAST_SLOT) ? '0 : rp_r + 1'b1;
  assign wp_dec = (wp_r == '0) ? LAST_SLOT : wp_r - 1'b1;
  assign empty  = (rp_r == wp_r);

  always_comb begin
    rp_nxt     = rp_r;
    wp_nxt     = wp_r;
    status_nxt = ST_OK;
    get_ok_nxt = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    unique case (action_t'(action))
      ACT_PUT: begin
        if (wp_inc == rp_r) begin
          status_nxt = ST_FULL;
        end else begin
          we     = cmd.exec;
          wp_nxt = wp_inc;
        end
      end
      ACT_GET: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          re         = cmd.exec;
          get_ok_nxt = 1'b1;
          rp_nxt     = rp_inc;
        end
      end
      ACT_BACKSPACE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          wp_nxt = wp_dec;
        end
      end
      ACT_CLEAR: begin
        rp_nxt = '0;
        wp_nxt = '0;
      end
      default: begin
        rp_nxt = rp_r;
      end
    endcase
  end

  // occupancy modulo slot count
  assign diff    = {1'b0, wp_nxt} - {1'b0, rp_nxt};
  assign cnt_nxt = diff[PW] ? diff[PW-1:0] + SLOT_LOW : diff[PW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r  <= '0;
      wp_r  <= '0;
      cnt_r <= '0;
    end else if (cmd.exec) begin
      rp_r  <= rp_nxt;
      wp_r  <= wp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
      get_ok_r <= get_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wp_r] <= data_in;
    end
    if (re) begin
      rd_r <= mem[rp_r];
    end
  end

  assign status     = status_r;
  assign data_out   = get_ok_r ? rd_r : '0;
  assign fill_count = FILL_W'(cnt_r);

endmodule
